@@ src/alab_pkg.sv @@
// Shared constants for the ambient-light auto-brightness block.
// Field widths, fixed-point constants and register indexes; no dependencies.
package alab_pkg;

	localparam int RAW_W      = 12;
	localparam int DT_W       = 16;
	localparam int BRT_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int unsigned ADC_FULL_SCALE = 4095;
	localparam int FS_W = $clog2(ADC_FULL_SCALE + 1);

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 21;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Shared divider: numerator width and quotient bits per division
	localparam int NUM_W     = 48;
	localparam int DIV_STEPS = 21;

	localparam logic [16:0] Q16_ONE      = 17'd65536;
	localparam logic [20:0] LOG2E_Q16    = 21'd94548;
	localparam logic [23:0] EXP_MAG_MAX  = 24'd1114112;
	localparam logic [23:0] EXP_MAG_OVER = 24'd1114113;
	localparam logic [15:0] GAMMA_UNITY  = 16'd4096;
	localparam logic [15:0] GAIN_UNITY   = 16'd256;

	// Light fraction saturates once the quotient would exceed one
	localparam logic [NUM_W-1:0] LIGHT_SAT = NUM_W'(64'd65537 * 64'(ADC_FULL_SCALE));
	localparam logic [NUM_W-1:0] FS_HALF   = NUM_W'(ADC_FULL_SCALE / 2);

	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ON_GROUND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_GAIN        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA_EXPONENT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHTNESS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHTNESS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_TIME_MS = 3'd5;

	localparam logic [15:0] RST_LIGHT_GAIN     = 16'd256;
	localparam logic [15:0] RST_GAMMA_EXPONENT = 16'd4096;
	localparam logic [7:0]  RST_MIN_BRIGHTNESS = 8'd2;
	localparam logic [7:0]  RST_MAX_BRIGHTNESS = 8'd180;
	localparam logic [15:0] RST_SMOOTHING_MS   = 16'd1000;

endpackage

@@ src/alab_in_if.sv @@
// Input channel: one ADC sample and the elapsed time per item.
// Depends on alab_pkg.
interface alab_in_if;
	import alab_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_sample;
	logic [DT_W-1:0]  elapsed_ms;
	modport source (output valid, raw_sample, elapsed_ms, input ready);
	modport sink (input valid, raw_sample, elapsed_ms, output ready);
endinterface

@@ src/alab_out_if.sv @@
// Output channel: one display brightness per item.
// Depends on alab_pkg.
interface alab_out_if;
	import alab_pkg::*;
	logic             valid;
	logic             ready;
	logic [BRT_W-1:0] brightness;
	modport source (output valid, brightness, input ready);
	modport sink (input valid, brightness, output ready);
endinterface

@@ src/ambient_light_auto_brightness.sv @@
// Ambient-light auto brightness: sample -> gain -> gamma -> range -> smoothing.
// Linear gamma skips the log2/exp2 work and a snapped level skips smoothing; a
// saturated light fraction skips its division. With gamma and smoothing, each of
// the two exp2 binary searches reruns the 16-step log2 squaring loop on the shared
// 24x21 multiplier, and each division runs on the shared restoring divider. One
// item at a time; reset restores the configuration defaults and clears the state,
// the output valid flag, the level and the primed flag.
module ambient_light_auto_brightness (
	input  logic                               clk,
	input  logic                               arst_n,
	alab_in_if.sink                            sample,
	alab_out_if.source                         result,
	input  logic                               cfg_we,
	input  logic [alab_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [alab_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import alab_pkg::*;

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_NMUL   = 5'd1;
	localparam logic [4:0] ST_NCHK   = 5'd2;
	localparam logic [4:0] ST_DIV    = 5'd3;
	localparam logic [4:0] ST_GCHK   = 5'd4;
	localparam logic [4:0] ST_LSTART = 5'd5;
	localparam logic [4:0] ST_LSQ    = 5'd6;
	localparam logic [4:0] ST_LDONE  = 5'd7;
	localparam logic [4:0] ST_GMUL   = 5'd8;
	localparam logic [4:0] ST_GMAG   = 5'd9;
	localparam logic [4:0] ST_XSTART = 5'd10;
	localparam logic [4:0] ST_BS     = 5'd11;
	localparam logic [4:0] ST_TMUL   = 5'd12;
	localparam logic [4:0] ST_TGT    = 5'd13;
	localparam logic [4:0] ST_DMUL   = 5'd14;
	localparam logic [4:0] ST_DNUM   = 5'd15;
	localparam logic [4:0] ST_DLIM   = 5'd16;
	localparam logic [4:0] ST_DCHK   = 5'd17;
	localparam logic [4:0] ST_SMUL   = 5'd18;
	localparam logic [4:0] ST_SUPD   = 5'd19;
	localparam logic [4:0] ST_OUT    = 5'd20;

	function automatic logic [3:0] top_bit(input logic [15:0] x);
		logic [3:0] p;
		p = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (x[i]) p = 4'(i);
		end
		return p;
	endfunction

	// configuration
	logic        sensor_on_ground_q;
	logic [15:0] light_gain_q, gamma_exponent_q, smoothing_time_ms_q;
	logic [7:0]  min_brightness_q, max_brightness_q;

	// control
	logic [4:0]  state_q;
	logic        primed_q, out_valid_q;
	logic [23:0] level_q;

	// datapath
	logic [FS_W-1:0]      c_q;
	logic [DT_W-1:0]      dt_q;
	logic [PROD_W-1:0]    prod_q;
	logic [NUM_W-1:0]     num_q;
	logic [15:0]          rem_q, div_d_q;
	logic [DIV_STEPS-1:0] sh_q;
	logic [4:0]           cnt_q;
	logic                 div_decay_q, exp_decay_q, search_q;
	logic [16:0]          n_q, mid_q, ans_q, decay_q;
	logic [17:0]          a_q, b_q;
	logic [15:0]          m_q, frac_q;
	logic [4:0]           p_q;
	logic [20:0]          lg_q;
	logic [23:0]          mag_q;
	logic [7:0]           target_q;
	logic [BRT_W-1:0]     out_data_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic [15:0]        gain_eff;
	logic [7:0]         lo, hi;
	logic [23:0]        goal, diff;
	logic               up;
	logic [16:0]        alpha;
	logic [16:0]        div_t;
	logic               div_ge;
	logic [16:0]        log_x;
	logic [16:0]        sq;
	logic [20:0]        lval;
	logic [17:0]        ab_sum;
	logic               exp_fin;
	logic [16:0]        exp_res;
	logic [NUM_W-1:0]   light_num;
	logic [15:0]        raw16, clamp16;
	logic [24:0]        tgt_sum;
	logic [7:0]         tgt;
	logic [8:0]         res_full;
	logic               out_load;
	logic [15:0]        lsq_m;
	logic [3:0]         lp;

	always_comb begin
		gain_eff = (light_gain_q == 16'd0) ? GAIN_UNITY : light_gain_q;
		lo = (min_brightness_q < max_brightness_q) ? min_brightness_q : max_brightness_q;
		hi = (min_brightness_q < max_brightness_q) ? max_brightness_q : min_brightness_q;
		goal = {target_q, 16'd0};
		up = goal >= level_q;
		diff = up ? goal - level_q : level_q - goal;
		alpha = Q16_ONE - decay_q;
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_NMUL: begin
				mul_a = MUL_A_W'(c_q);
				mul_b = MUL_B_W'(gain_eff);
			end
			ST_LSQ: begin
				mul_a = MUL_A_W'(m_q);
				mul_b = MUL_B_W'(m_q);
			end
			ST_GMUL: begin
				mul_a = MUL_A_W'(lg_q);
				mul_b = MUL_B_W'(gamma_exponent_q);
			end
			ST_TMUL: begin
				mul_a = MUL_A_W'(n_q);
				mul_b = MUL_B_W'(hi - lo);
			end
			ST_DMUL: begin
				mul_a = MUL_A_W'(dt_q);
				mul_b = LOG2E_Q16;
			end
			ST_DLIM: begin
				mul_a = EXP_MAG_OVER;
				mul_b = MUL_B_W'(smoothing_time_ms_q);
			end
			ST_SMUL: begin
				mul_a = diff;
				mul_b = MUL_B_W'(alpha);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	always_comb begin
		raw16 = 16'(sample.raw_sample);
		clamp16 = (raw16 > 16'(ADC_FULL_SCALE)) ? 16'(ADC_FULL_SCALE) : raw16;
		if (sensor_on_ground_q) clamp16 = 16'(ADC_FULL_SCALE) - clamp16;

		light_num = NUM_W'({prod_q[FS_W+15:0], 8'd0}) + FS_HALF;

		div_t  = {rem_q, sh_q[DIV_STEPS-1]};
		div_ge = div_t >= {1'b0, div_d_q};

		log_x = search_q ? mid_q : n_q;
		lp    = top_bit(log_x[15:0]);
		sq    = prod[31:15];
		lsq_m = sq[16] ? sq[16:1] : sq[15:0];
		lval  = {5'd16 - p_q, 16'd0} - 21'(frac_q);

		ab_sum = a_q + b_q;

		exp_fin = 1'b0;
		exp_res = ans_q;
		if (state_q == ST_XSTART) begin
			if (mag_q == 24'd0) begin
				exp_fin = 1'b1;
				exp_res = Q16_ONE;
			end else if (mag_q > EXP_MAG_MAX) begin
				exp_fin = 1'b1;
				exp_res = 17'd0;
			end
		end else if (state_q == ST_BS && a_q > b_q) begin
			exp_fin = 1'b1;
		end

		tgt_sum  = prod_q[24:0] + 25'd32768;
		tgt      = lo + tgt_sum[23:16];
		res_full = 9'(({1'b0, level_q} + 25'd32768) >> 16);
		out_load = (state_q == ST_OUT) && (!out_valid_q || result.ready);
	end

	assign sample.ready      = (state_q == ST_IDLE);
	assign result.valid      = out_valid_q;
	assign result.brightness = out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_on_ground_q  <= 1'b0;
			light_gain_q        <= RST_LIGHT_GAIN;
			gamma_exponent_q    <= RST_GAMMA_EXPONENT;
			min_brightness_q    <= RST_MIN_BRIGHTNESS;
			max_brightness_q    <= RST_MAX_BRIGHTNESS;
			smoothing_time_ms_q <= RST_SMOOTHING_MS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENSOR_ON_GROUND:  sensor_on_ground_q  <= cfg_wdata[0];
				REG_LIGHT_GAIN:        light_gain_q        <= cfg_wdata;
				REG_GAMMA_EXPONENT:    gamma_exponent_q    <= cfg_wdata;
				REG_MIN_BRIGHTNESS:    min_brightness_q    <= cfg_wdata[7:0];
				REG_MAX_BRIGHTNESS:    max_brightness_q    <= cfg_wdata[7:0];
				REG_SMOOTHING_TIME_MS: smoothing_time_ms_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
			level_q     <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE:   if (sample.valid) state_q <= ST_NMUL;
				ST_NMUL:   state_q <= ST_NCHK;
				ST_NCHK:   state_q <= (light_num >= LIGHT_SAT) ? ST_GCHK : ST_DIV;
				ST_DIV: begin
					if (cnt_q == 5'(DIV_STEPS - 1)) state_q <= div_decay_q ? ST_XSTART : ST_GCHK;
				end
				ST_GCHK: begin
					if (gamma_exponent_q != 16'd0 && gamma_exponent_q != GAMMA_UNITY &&
					    n_q != 17'd0 && n_q != Q16_ONE) state_q <= ST_LSTART;
					else state_q <= ST_TMUL;
				end
				ST_LSTART: state_q <= log_x[16] ? ST_LDONE : ST_LSQ;
				ST_LSQ:    if (cnt_q == 5'd15) state_q <= ST_LDONE;
				ST_LDONE:  state_q <= search_q ? ST_BS : ST_GMUL;
				ST_GMUL:   state_q <= ST_GMAG;
				ST_GMAG:   state_q <= ST_XSTART;
				ST_XSTART, ST_BS: begin
					if (exp_fin) state_q <= exp_decay_q ? ST_SMUL : ST_TMUL;
					else if (state_q == ST_BS) state_q <= ST_LSTART;
					else state_q <= ST_BS;
				end
				ST_TMUL:   state_q <= ST_TGT;
				ST_TGT: begin
					if (!primed_q || smoothing_time_ms_q == 16'd0 || dt_q == '0) begin
						level_q  <= {tgt, 16'd0};
						primed_q <= 1'b1;
						state_q  <= ST_OUT;
					end else begin
						state_q <= ST_DMUL;
					end
				end
				ST_DMUL:   state_q <= ST_DNUM;
				ST_DNUM:   state_q <= ST_DLIM;
				ST_DLIM:   state_q <= ST_DCHK;
				ST_DCHK:   state_q <= (num_q >= NUM_W'(prod_q[36:0])) ? ST_SMUL : ST_DIV;
				ST_SMUL:   state_q <= ST_SUPD;
				ST_SUPD: begin
					// never overshoots: step is at most the distance
					if (up) level_q <= level_q + prod_q[39:16];
					else level_q <= level_q - prod_q[39:16];
					state_q <= ST_OUT;
				end
				ST_OUT:    if (out_load) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod;
		if (out_load) out_data_q <= res_full[8] ? 8'hFF : res_full[7:0];

		case (state_q)
			ST_IDLE: begin
				c_q  <= FS_W'(clamp16);
				dt_q <= sample.elapsed_ms;
			end
			ST_NCHK: begin
				if (light_num >= LIGHT_SAT) begin
					n_q <= Q16_ONE;
				end else begin
					rem_q       <= light_num[DIV_STEPS+15:DIV_STEPS];
					sh_q        <= light_num[DIV_STEPS-1:0];
					div_d_q     <= 16'(ADC_FULL_SCALE);
					div_decay_q <= 1'b0;
					cnt_q       <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? 16'(div_t - {1'b0, div_d_q}) : div_t[15:0];
				sh_q  <= {sh_q[DIV_STEPS-2:0], div_ge};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					if (div_decay_q) begin
						mag_q       <= 24'({sh_q[DIV_STEPS-2:0], div_ge});
						exp_decay_q <= 1'b1;
					end else begin
						n_q <= 17'({sh_q[DIV_STEPS-2:0], div_ge});
					end
				end
			end
			ST_GCHK:   search_q <= 1'b0;
			ST_LSTART: begin
				frac_q <= '0;
				cnt_q  <= '0;
				if (log_x[16]) begin
					p_q <= 5'd16;
				end else begin
					p_q <= 5'(lp);
					m_q <= log_x[15:0] << (4'd15 - lp);
				end
			end
			ST_LSQ: begin
				m_q    <= lsq_m;
				frac_q <= {frac_q[14:0], sq[16]};
				cnt_q  <= cnt_q + 5'd1;
			end
			ST_LDONE: begin
				if (search_q) begin
					if (24'(lval) >= mag_q) begin
						ans_q <= mid_q;
						a_q   <= 18'(mid_q) + 18'd1;
					end else begin
						b_q <= 18'(mid_q) - 18'd1;
					end
				end else begin
					lg_q <= lval;
				end
			end
			ST_GMAG: begin
				mag_q       <= prod_q[35:12];
				exp_decay_q <= 1'b0;
			end
			ST_XSTART, ST_BS: begin
				if (exp_fin) begin
					if (exp_decay_q) decay_q <= exp_res;
					else n_q <= exp_res;
				end else if (state_q == ST_BS) begin
					mid_q <= ab_sum[17:1];
				end else begin
					a_q      <= 18'd1;
					b_q      <= 18'(Q16_ONE);
					ans_q    <= '0;
					search_q <= 1'b1;
				end
			end
			ST_TGT:  target_q <= tgt;
			ST_DNUM: num_q <= NUM_W'(prod_q[32:0]) + NUM_W'(smoothing_time_ms_q >> 1);
			ST_DCHK: begin
				if (num_q >= NUM_W'(prod_q[36:0])) begin
					decay_q <= '0;
				end else begin
					rem_q       <= num_q[DIV_STEPS+15:DIV_STEPS];
					sh_q        <= num_q[DIV_STEPS-1:0];
					div_d_q     <= smoothing_time_ms_q;
					div_decay_q <= 1'b1;
					cnt_q       <= '0;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ src/alab_checker.sv @@
// Port-level checks for the auto-brightness block, bound to its top level.
// Depends on alab_pkg and the top level's channel ports only.
module alab_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [alab_pkg::BRT_W-1:0] brightness
);
	import alab_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(brightness))
		else $error("brightness changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared the cycle after an item was taken");

endmodule

bind ambient_light_auto_brightness alab_checker u_alab_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample.valid),
	.in_ready   (sample.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.brightness (result.brightness)
);
